@@ hdl/ucnt_pkg.sv @@
package ucnt_pkg;

  localparam int VALUE_W     = 64;
  localparam int COUNT_W     = 32;
  localparam int SLOT_W      = 6;
  localparam int KIND_W      = 2;
  localparam int RKIND_W     = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 2;
  localparam int QUEUE_DEPTH = 2;

  // Element kinds.
  localparam logic [KIND_W-1:0] KIND_INT32   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INT64   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLOAT32 = 2'd2;

  // Result kinds.
  localparam logic [RKIND_W-1:0] RES_ELEMENT  = 2'd0;
  localparam logic [RKIND_W-1:0] RES_DISTINCT = 2'd1;
  localparam logic [RKIND_W-1:0] RES_EMPTY    = 2'd2;

  // Commands.
  localparam logic CMD_ELEMENT = 1'b0;
  localparam logic CMD_FINISH  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_ELEMENT_KIND = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COUNT_ENABLE = 2'd1;

  typedef struct packed {
    logic               command;
    logic [VALUE_W-1:0] element_value;
  } item_t;

  typedef struct packed {
    logic [RKIND_W-1:0] result_kind;
    logic [SLOT_W-1:0]  slot_index;
    logic [VALUE_W-1:0] distinct_value;
    logic [COUNT_W-1:0] occurrences;
    logic               table_overflow;
    logic               last_entry;
  } result_t;

  // Classified item as it waits between the front and the back.
  typedef struct packed {
    logic               finish;
    logic [VALUE_W-1:0] key;
    logic               is_nan;
    logic               is_zero;
  } entry_t;

  typedef struct packed {
    logic [KIND_W-1:0] element_kind;
    logic              count_enable;
  } cfg_t;

  function automatic logic is_nan32(logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  function automatic logic is_zero32(logic [31:0] v);
    return v[30:0] == 31'd0;
  endfunction

endpackage

@@ hdl/unique_with_counts_unit.sv @@
// Unique-with-counts unit: classifies a tensor's elements against a table of
// distinct values kept in first-seen order.
// Channels: item (item_valid, item_stall, item) carries one element or a
// finish command per beat; result (result_valid, result_stall, result) carries
// one result per beat; cfg (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// element_kind and count_enable, and is always ready. Write it only while idle.
// Every element beat yields one result beat holding its slot. A finish beat
// yields one beat per stored distinct value in slot order, the final one with
// last_entry set, or a single empty marker if the table holds nothing.
// An accepted item passes the front queue and then the result register on
// its way to its result beat. Elements flow at one per cycle while
// result_stall is low, set by the combinational compare of the incoming key
// against all TABLE_DEPTH cells. A finish enters a drain state that yields
// one stored value per beat, shifting the table down by one cell per beat.
// Reset empties the table and restores element_kind int32 and counting on.
// No clearing pass is needed. While result_stall is high the result beat
// holds, and the two-entry queue in front keeps taking items until it fills,
// at which point item_stall rises.
module unique_with_counts_unit
  import ucnt_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result
);

  cfg_t   cfg;
  logic   q_valid;
  logic   q_pop;
  entry_t q_entry;

  // The configuration port never pushes back.
  assign cfg_ready = 1'b1;

  // Writes to an index beyond the two registers are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.element_kind <= KIND_INT32;
      cfg.count_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ELEMENT_KIND: begin
          cfg.element_kind <= cfg_data[KIND_W-1:0];
        end
        CFG_COUNT_ENABLE: begin
          cfg.count_enable <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Front: narrows each key to the element kind, flags float NaN and zero,
  // and buffers the beat so the table side can stall independently.
  ucnt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop)
  );

  // Back: the table of distinct values, its drain sequencer and the result
  // register.
  ucnt_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

@@ hdl/ucnt_front.sv @@
module ucnt_front
  import ucnt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   item_valid,
  output logic   item_stall,
  input  item_t  item,
  output logic   q_valid,
  output entry_t q_entry,
  input  logic   q_pop
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slots_q [QUEUE_DEPTH];
  entry_t             classified;
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [FILL_W-1:0]  fill;
  logic [FILL_W-1:0]  fill_next;
  logic               push;

  // Narrow the key to the element kind and flag float NaN and zero.
  always_comb begin
    classified.finish  = (item.command == CMD_FINISH);
    classified.is_nan  = is_nan32(item.element_value[31:0]);
    classified.is_zero = is_zero32(item.element_value[31:0]);
    case (cfg.element_kind)
      KIND_INT32, KIND_FLOAT32: begin
        classified.key = {32'd0, item.element_value[31:0]};
      end
      default: begin
        classified.key = item.element_value;
      end
    endcase
  end

  assign item_stall = (fill == FILL_W'(QUEUE_DEPTH));
  assign push       = item_valid && !item_stall;
  assign q_valid    = (fill != '0);
  assign q_entry    = slots_q[rd_ptr];

  always_comb begin
    fill_next = fill;
    if (push && !q_pop) begin
      fill_next = fill + FILL_W'(1);
    end else if (!push && q_pop) begin
      fill_next = fill - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_q[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

endmodule

@@ hdl/ucnt_back.sv @@
module ucnt_back
  import ucnt_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_valid,
  input  entry_t  q_entry,
  output logic    q_pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic {
    ST_RUN,
    ST_DRAIN
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         slots_used;
  logic [CNT_W-1:0]         drain_pos;
  logic [VALUE_W-1:0]       key_cells   [TABLE_DEPTH];
  logic [COUNT_W-1:0]       count_cells [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]   hit;
  logic [TABLE_DEPTH-1:0]   first_hit;
  logic [IDX_W-1:0]         hit_idx;
  logic                     any_hit;
  logic                     table_full;
  logic                     can_emit;
  logic                     take;
  logic                     do_store;
  logic                     do_bump;
  logic                     do_shift;
  logic                     drain_last;
  result_t                  elem_result;
  result_t                  drain_result;
  result_t                  empty_result;

  // Compare the incoming key against every occupied cell at once.
  always_comb begin
    logic [VALUE_W-1:0] k;
    logic               lo_eq;
    logic               hi_eq;
    logic               a_nan;
    logic               a_zero;
    hit = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      k      = key_cells[i];
      lo_eq  = (k[31:0] == q_entry.key[31:0]);
      hi_eq  = (k[63:32] == q_entry.key[63:32]);
      a_nan  = is_nan32(k[31:0]);
      a_zero = is_zero32(k[31:0]);
      if (CNT_W'(i) < slots_used) begin
        case (cfg.element_kind)
          KIND_INT32: begin
            hit[i] = lo_eq;
          end
          KIND_FLOAT32: begin
            hit[i] = !a_nan && !q_entry.is_nan && ((a_zero && q_entry.is_zero) || lo_eq);
          end
          default: begin
            hit[i] = lo_eq && hi_eq;
          end
        endcase
      end
    end
  end

  assign first_hit = hit & (~hit + TABLE_DEPTH'(1));
  assign any_hit   = |hit;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (first_hit[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign table_full = (slots_used == CNT_W'(TABLE_DEPTH));
  assign can_emit   = !result_valid || !result_stall;
  assign take       = (state == ST_RUN) && q_valid && can_emit;
  assign q_pop      = take;
  assign do_bump    = take && !q_entry.finish && any_hit;
  assign do_store   = take && !q_entry.finish && !any_hit && !table_full;
  assign do_shift   = (state == ST_DRAIN) && can_emit;
  assign drain_last = ((drain_pos + CNT_W'(1)) == slots_used);

  // Table cells: each cell loads, counts or takes its upper neighbor on a drain.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [VALUE_W-1:0] up_key;
    logic [COUNT_W-1:0] up_count;
    if (i < TABLE_DEPTH - 1) begin : g_mid
      assign up_key   = key_cells[i+1];
      assign up_count = count_cells[i+1];
    end else begin : g_top
      assign up_key   = key_cells[i];
      assign up_count = count_cells[i];
    end

    always_ff @(posedge clk) begin
      if (do_shift) begin
        key_cells[i]   <= up_key;
        count_cells[i] <= up_count;
      end else if (do_store && (slots_used == CNT_W'(i))) begin
        key_cells[i]   <= q_entry.key;
        count_cells[i] <= COUNT_W'(1);
      end else if (do_bump && first_hit[i] && (count_cells[i] != '1)) begin
        count_cells[i] <= count_cells[i] + COUNT_W'(1);
      end
    end
  end

  always_comb begin
    elem_result                = '0;
    elem_result.result_kind    = RES_ELEMENT;
    elem_result.table_overflow = !any_hit && table_full;
    if (any_hit) begin
      elem_result.slot_index = SLOT_W'(hit_idx);
    end else if (!table_full) begin
      elem_result.slot_index = SLOT_W'(slots_used);
    end

    drain_result                = '0;
    drain_result.result_kind    = RES_DISTINCT;
    drain_result.slot_index     = SLOT_W'(drain_pos);
    drain_result.distinct_value = key_cells[0];
    drain_result.occurrences    = cfg.count_enable ? count_cells[0] : '0;
    drain_result.last_entry     = drain_last;

    empty_result             = '0;
    empty_result.result_kind = RES_EMPTY;
    empty_result.last_entry  = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RUN;
      slots_used   <= '0;
      drain_pos    <= '0;
      result_valid <= 1'b0;
    end else begin
      case (state)
        ST_RUN: begin
          if (take) begin
            if (!q_entry.finish) begin
              result_valid <= 1'b1;
              result       <= elem_result;
              if (do_store) begin
                slots_used <= slots_used + CNT_W'(1);
              end
            end else if (slots_used == '0) begin
              result_valid <= 1'b1;
              result       <= empty_result;
            end else begin
              result_valid <= 1'b0;
              drain_pos    <= '0;
              state        <= ST_DRAIN;
            end
          end else if (can_emit) begin
            result_valid <= 1'b0;
          end
        end
        ST_DRAIN: begin
          if (can_emit) begin
            result_valid <= 1'b1;
            result       <= drain_result;
            drain_pos    <= drain_pos + CNT_W'(1);
            if (drain_last) begin
              slots_used <= '0;
              state      <= ST_RUN;
            end
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

endmodule

@@ hdl/ucnt_checker.sv @@
module ucnt_checker
  import ucnt_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // A stalled result beat holds its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // A drain runs without gaps: each taken entry that is not the last is
  // followed at once by the entry of the next slot.
  a_drain_next: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && (result.result_kind == RES_DISTINCT)
    && !result.last_entry
    |=> result_valid && (result.result_kind == RES_DISTINCT)
    && (result.slot_index == SLOT_W'($past(result.slot_index) + 1'b1)))
    else $error("drain sequence broken");

  // No result beat right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // Overflow only on element results, which then report slot zero.
  a_overflow_form: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.table_overflow
    |-> (result.result_kind == RES_ELEMENT) && (result.slot_index == '0)
    && !result.last_entry)
    else $error("malformed overflow result");

endmodule

bind unique_with_counts_unit ucnt_checker u_ucnt_checker (.*);
